[rtl/core/onf_pkg.sv]
// Shared constants, codes and command/status types of the octave value-noise field.
package onf_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int MAX_OCTAVES = 8;
	localparam int SAMPLE_BITS = 16;

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int IDX_W       = 12;
	localparam int CFG_W       = 7;
	localparam int OCT_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int SH_W        = 4;

	localparam int BLEND_BITS  = 8;
	localparam int BLEND_W     = BLEND_BITS + 1;
	localparam int TOP_W       = SAMPLE_BITS + BLEND_BITS;
	localparam int PROD_W      = SAMPLE_BITS + 2 * BLEND_BITS;
	localparam int ACC_W       = PROD_W + MAX_OCTAVES;

	localparam int DVD_W       = ACC_W - 2 * BLEND_BITS;
	localparam int DVS_W       = 8;
	localparam int DCNT_W      = $clog2(DVD_W + 1);
	localparam int NB_IDX      = IDX_W;
	localparam int NB_GRID     = BLEND_BITS + 1;
	localparam int NB_ACC      = DVD_W;

	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_OCTAVES = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_READ = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		DSEL_IDX,
		DSEL_ROW,
		DSEL_I1,
		DSEL_J1,
		DSEL_ACC
	} div_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIDX_GO,
		S_DIDX_WT,
		S_DROW_GO,
		S_DROW_WT,
		S_SETUP,
		S_DI1_GO,
		S_DI1_WT,
		S_DJ1_GO,
		S_DJ1_WT,
		S_RD0,
		S_RD1,
		S_RD2,
		S_RD3,
		S_RD4,
		S_TOP,
		S_BOT,
		S_V1,
		S_V2,
		S_DACC_GO,
		S_DACC_WT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic       load_wr;
		logic       accept_read;
		logic       div_start;
		div_sel_t   div_sel;
		logic       cap_div;
		logic       oct_init;
		logic       oct_setup;
		logic       rd_en;
		logic [1:0] rd_corner;
		logic       cap_en;
		logic [1:0] cap_corner;
		logic       blend_top;
		logic       blend_bot;
		logic       blend_v1;
		logic       blend_v2;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_idle;
		logic last_oct;
		logic out_free;
	} status_t;

endpackage

[rtl/core/onf_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module onf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [onf_pkg::DVD_W-1:0]   dividend,
	input  logic [onf_pkg::DVS_W-1:0]   divisor,
	input  logic [onf_pkg::DCNT_W-1:0]  nbits,
	output logic                        idle,
	output logic [onf_pkg::DVD_W-1:0]   quotient,
	output logic [onf_pkg::DVS_W-1:0]   remainder
);

	logic [onf_pkg::DCNT_W-1:0] cnt_q;
	logic [onf_pkg::DVD_W-1:0]  quo_q;
	logic [onf_pkg::DVS_W-1:0]  rem_q;
	logic [onf_pkg::DVS_W-1:0]  div_q;
	logic [onf_pkg::DVS_W:0]    trial;
	logic                       fits;

	assign trial = {rem_q, quo_q[onf_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= nbits;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - onf_pkg::DCNT_W'(1);
		end
	end

	// top-align the dividend so that exactly nbits steps consume it
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend << (onf_pkg::DCNT_W'(onf_pkg::DVD_W) - nbits);
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[onf_pkg::DVD_W-2:0], fits};
			rem_q <= fits ? onf_pkg::DVS_W'(trial - {1'b0, div_q})
			              : onf_pkg::DVS_W'(trial);
		end
	end

	assign idle      = cnt_q == '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");
`endif

endmodule

[rtl/core/onf_datapath.sv]
// Datapath: config registers, base field memory, octave blend, accumulator, output register.
module onf_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [onf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [onf_pkg::CFG_W-1:0]     cfg_data,
	input  logic [onf_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [onf_pkg::OUT_DATA_W-1:0] m_tdata,
	input  onf_pkg::cmd_t                 cmd,
	output onf_pkg::status_t              status
);

	logic [onf_pkg::CFG_W-1:0] width_cfg_q, height_cfg_q;
	logic [onf_pkg::OCT_W-1:0] oct_cfg_q;

	logic [onf_pkg::SAMPLE_BITS-1:0] mem [onf_pkg::STORE_DEPTH];
	logic [onf_pkg::SAMPLE_BITS-1:0] rdata_q;

	logic [onf_pkg::IDX_W-1:0]      idx_in, idx_q, q_q;
	logic [onf_pkg::SAMPLE_BITS-1:0] sample_in;
	logic [onf_pkg::CFG_W-1:0]      w_q, h_q;
	logic [onf_pkg::OCT_W-1:0]      n_q;
	logic [onf_pkg::COL_W-1:0]      x_q, i0_q, i1_q;
	logic [onf_pkg::ROW_W-1:0]      y_q, j0_q, j1_q;
	logic [onf_pkg::SH_W-1:0]       sh_q;
	logic [onf_pkg::BLEND_BITS-1:0] hb_q, vb_q;
	logic [onf_pkg::SAMPLE_BITS-1:0] s_q [4];
	logic [onf_pkg::TOP_W-1:0]      top_q, bot_q;
	logic [onf_pkg::PROD_W-1:0]     p_q;
	logic [onf_pkg::ACC_W-1:0]      acc_q;
	logic [onf_pkg::SAMPLE_BITS-1:0] res_q;
	logic                           m_tvalid_q;
	logic [onf_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic [onf_pkg::BLEND_BITS:0]   period;
	logic [onf_pkg::COL_W-1:0]      i0_new;
	logic [onf_pkg::ROW_W-1:0]      j0_new;
	logic [onf_pkg::COL_W+onf_pkg::BLEND_BITS-1:0] hsh;
	logic [onf_pkg::ROW_W+onf_pkg::BLEND_BITS-1:0] vsh;
	logic [onf_pkg::BLEND_W-1:0]    ihb, ivb;
	logic [onf_pkg::ROW_W-1:0]      rd_row;
	logic [onf_pkg::COL_W-1:0]      rd_col;
	logic [onf_pkg::ROW_W+onf_pkg::CFG_W-1:0] rd_lin;
	logic [onf_pkg::ADDR_W-1:0]     rd_addr;
	logic [onf_pkg::TOP_W:0]        edge_a, edge_b;
	logic [onf_pkg::PROD_W:0]       vprod;
	logic [onf_pkg::PROD_W-1:0]     bvb, term;

	logic [onf_pkg::DVD_W-1:0]      dvd, quo;
	logic [onf_pkg::DVS_W-1:0]      dvs, rem;
	logic [onf_pkg::DCNT_W-1:0]     nb;
	logic                           div_idle;

	assign idx_in    = s_tdata[onf_pkg::IDX_W-1:0];
	assign sample_in = s_tdata[onf_pkg::IDX_W +: onf_pkg::SAMPLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= onf_pkg::CFG_W'(onf_pkg::MAX_WIDTH);
			height_cfg_q <= onf_pkg::CFG_W'(onf_pkg::MAX_HEIGHT);
			oct_cfg_q    <= onf_pkg::OCT_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				onf_pkg::REG_WIDTH:   width_cfg_q  <= cfg_data;
				onf_pkg::REG_HEIGHT:  height_cfg_q <= cfg_data;
				onf_pkg::REG_OCTAVES: oct_cfg_q    <= cfg_data[onf_pkg::OCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && ({1'b0, idx_in} < (onf_pkg::IDX_W+1)'(onf_pkg::STORE_DEPTH))) begin
			mem[onf_pkg::ADDR_W'(idx_in)] <= sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// divider operand select
	always_comb begin
		dvd = '0;
		dvs = onf_pkg::DVS_W'(w_q);
		nb  = onf_pkg::DCNT_W'(onf_pkg::NB_IDX);
		unique case (cmd.div_sel)
			onf_pkg::DSEL_IDX: begin
				dvd = onf_pkg::DVD_W'(idx_q);
				dvs = onf_pkg::DVS_W'(w_q);
				nb  = onf_pkg::DCNT_W'(onf_pkg::NB_IDX);
			end
			onf_pkg::DSEL_ROW: begin
				dvd = onf_pkg::DVD_W'(q_q);
				dvs = onf_pkg::DVS_W'(h_q);
				nb  = onf_pkg::DCNT_W'(onf_pkg::NB_IDX);
			end
			onf_pkg::DSEL_I1: begin
				dvd = onf_pkg::DVD_W'(i0_q) + onf_pkg::DVD_W'(period);
				dvs = onf_pkg::DVS_W'(w_q);
				nb  = onf_pkg::DCNT_W'(onf_pkg::NB_GRID);
			end
			onf_pkg::DSEL_J1: begin
				dvd = onf_pkg::DVD_W'(j0_q) + onf_pkg::DVD_W'(period);
				dvs = onf_pkg::DVS_W'(h_q);
				nb  = onf_pkg::DCNT_W'(onf_pkg::NB_GRID);
			end
			onf_pkg::DSEL_ACC: begin
				dvd = acc_q[onf_pkg::ACC_W-1 -: onf_pkg::DVD_W];
				dvs = onf_pkg::DVS_W'(((onf_pkg::BLEND_BITS+1)'(1) << n_q)
				      - (onf_pkg::BLEND_BITS+1)'(1));
				nb  = onf_pkg::DCNT_W'(onf_pkg::NB_ACC);
			end
			default: ;
		endcase
	end

	onf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dvd),
		.divisor   (dvs),
		.nbits     (nb),
		.idle      (div_idle),
		.quotient  (quo),
		.remainder (rem)
	);

	assign period = (onf_pkg::BLEND_BITS+1)'(1) << sh_q;
	assign i0_new = (x_q >> sh_q) << sh_q;
	assign j0_new = (y_q >> sh_q) << sh_q;
	assign hsh    = ((onf_pkg::COL_W+onf_pkg::BLEND_BITS)'(x_q - i0_new)
	                 << onf_pkg::BLEND_BITS) >> sh_q;
	assign vsh    = ((onf_pkg::ROW_W+onf_pkg::BLEND_BITS)'(y_q - j0_new)
	                 << onf_pkg::BLEND_BITS) >> sh_q;
	assign ihb    = onf_pkg::BLEND_W'(1 << onf_pkg::BLEND_BITS) - {1'b0, hb_q};
	assign ivb    = onf_pkg::BLEND_W'(1 << onf_pkg::BLEND_BITS) - {1'b0, vb_q};

	assign rd_row  = cmd.rd_corner[1] ? j1_q : j0_q;
	assign rd_col  = cmd.rd_corner[0] ? i1_q : i0_q;
	assign rd_lin  = (onf_pkg::ROW_W+onf_pkg::CFG_W)'(rd_row)
	                 * (onf_pkg::ROW_W+onf_pkg::CFG_W)'(w_q)
	                 + (onf_pkg::ROW_W+onf_pkg::CFG_W)'(rd_col);
	assign rd_addr = onf_pkg::ADDR_W'(rd_lin);

	assign edge_a = (onf_pkg::TOP_W+1)'(s_q[0]) * (onf_pkg::TOP_W+1)'(ihb)
	              + (onf_pkg::TOP_W+1)'(s_q[1]) * (onf_pkg::TOP_W+1)'(hb_q);
	assign edge_b = (onf_pkg::TOP_W+1)'(s_q[2]) * (onf_pkg::TOP_W+1)'(ihb)
	              + (onf_pkg::TOP_W+1)'(s_q[3]) * (onf_pkg::TOP_W+1)'(hb_q);
	assign vprod  = (onf_pkg::PROD_W+1)'(top_q) * (onf_pkg::PROD_W+1)'(ivb);
	assign bvb    = onf_pkg::PROD_W'(bot_q) * onf_pkg::PROD_W'(vb_q);
	assign term   = p_q + bvb;

	always_ff @(posedge clk) begin
		if (cmd.accept_read) begin
			idx_q <= idx_in;
			w_q   <= (width_cfg_q == '0) ? onf_pkg::CFG_W'(1)
			       : (width_cfg_q > onf_pkg::CFG_W'(onf_pkg::MAX_WIDTH))
			         ? onf_pkg::CFG_W'(onf_pkg::MAX_WIDTH) : width_cfg_q;
			h_q   <= (height_cfg_q == '0) ? onf_pkg::CFG_W'(1)
			       : (height_cfg_q > onf_pkg::CFG_W'(onf_pkg::MAX_HEIGHT))
			         ? onf_pkg::CFG_W'(onf_pkg::MAX_HEIGHT) : height_cfg_q;
			n_q   <= (oct_cfg_q == '0) ? onf_pkg::OCT_W'(1)
			       : (oct_cfg_q > onf_pkg::OCT_W'(onf_pkg::MAX_OCTAVES))
			         ? onf_pkg::OCT_W'(onf_pkg::MAX_OCTAVES) : oct_cfg_q;
		end
		if (cmd.cap_div) begin
			unique case (cmd.div_sel)
				onf_pkg::DSEL_IDX: begin
					x_q <= onf_pkg::COL_W'(rem);
					q_q <= onf_pkg::IDX_W'(quo);
				end
				onf_pkg::DSEL_ROW: y_q  <= onf_pkg::ROW_W'(rem);
				onf_pkg::DSEL_I1:  i1_q <= onf_pkg::COL_W'(rem);
				onf_pkg::DSEL_J1:  j1_q <= onf_pkg::ROW_W'(rem);
				onf_pkg::DSEL_ACC: res_q <= (quo > onf_pkg::DVD_W'({onf_pkg::SAMPLE_BITS{1'b1}}))
				                   ? {onf_pkg::SAMPLE_BITS{1'b1}}
				                   : onf_pkg::SAMPLE_BITS'(quo);
				default: ;
			endcase
		end
		if (cmd.oct_init) begin
			sh_q  <= onf_pkg::SH_W'(n_q);
			acc_q <= '0;
		end
		if (cmd.oct_setup) begin
			i0_q <= i0_new;
			j0_q <= j0_new;
			hb_q <= onf_pkg::BLEND_BITS'(hsh);
			vb_q <= onf_pkg::BLEND_BITS'(vsh);
		end
		if (cmd.cap_en) begin
			s_q[cmd.cap_corner] <= rdata_q;
		end
		if (cmd.blend_top) begin
			top_q <= onf_pkg::TOP_W'(edge_a);
		end
		if (cmd.blend_bot) begin
			bot_q <= onf_pkg::TOP_W'(edge_b);
		end
		if (cmd.blend_v1) begin
			p_q <= onf_pkg::PROD_W'(vprod);
		end
		// coarser octaves carry more weight: shift by the remaining octave count
		if (cmd.blend_v2) begin
			acc_q <= acc_q + (onf_pkg::ACC_W'(term) << (sh_q - onf_pkg::SH_W'(1)));
			sh_q  <= sh_q - onf_pkg::SH_W'(1);
		end
		if (cmd.out_load) begin
			m_tdata_q <= onf_pkg::OUT_DATA_W'({idx_q, res_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid        = m_tvalid_q;
	assign m_tdata         = m_tdata_q;
	assign status.div_idle = div_idle;
	assign status.last_oct = sh_q == onf_pkg::SH_W'(1);
	assign status.out_free = !m_tvalid_q || m_tready;

`ifndef SYNTHESIS
	a_coord_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.oct_setup |-> ((onf_pkg::CFG_W'(x_q) < w_q) && (onf_pkg::CFG_W'(y_q) < h_q)))
		else $error("pixel coordinate outside field");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("output register overwritten while held");
`endif

endmodule

[rtl/core/onf_ctrl.sv]
// Controller: sequences divides, corner reads, blends and octaves for one pixel.
module onf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             req_type,
	input  onf_pkg::status_t status,
	output onf_pkg::cmd_t    cmd
);

	onf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= onf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			onf_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (req_type == onf_pkg::REQ_READ) begin
						cmd.accept_read = 1'b1;
						state_d = onf_pkg::S_DIDX_GO;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			onf_pkg::S_DIDX_GO: begin
				cmd.div_sel   = onf_pkg::DSEL_IDX;
				cmd.div_start = 1'b1;
				state_d = onf_pkg::S_DIDX_WT;
			end
			onf_pkg::S_DIDX_WT: begin
				cmd.div_sel = onf_pkg::DSEL_IDX;
				if (status.div_idle) begin
					cmd.cap_div = 1'b1;
					state_d = onf_pkg::S_DROW_GO;
				end
			end
			onf_pkg::S_DROW_GO: begin
				cmd.div_sel   = onf_pkg::DSEL_ROW;
				cmd.div_start = 1'b1;
				state_d = onf_pkg::S_DROW_WT;
			end
			onf_pkg::S_DROW_WT: begin
				cmd.div_sel = onf_pkg::DSEL_ROW;
				if (status.div_idle) begin
					cmd.cap_div  = 1'b1;
					cmd.oct_init = 1'b1;
					state_d = onf_pkg::S_SETUP;
				end
			end
			onf_pkg::S_SETUP: begin
				cmd.oct_setup = 1'b1;
				state_d = onf_pkg::S_DI1_GO;
			end
			onf_pkg::S_DI1_GO: begin
				cmd.div_sel   = onf_pkg::DSEL_I1;
				cmd.div_start = 1'b1;
				state_d = onf_pkg::S_DI1_WT;
			end
			onf_pkg::S_DI1_WT: begin
				cmd.div_sel = onf_pkg::DSEL_I1;
				if (status.div_idle) begin
					cmd.cap_div = 1'b1;
					state_d = onf_pkg::S_DJ1_GO;
				end
			end
			onf_pkg::S_DJ1_GO: begin
				cmd.div_sel   = onf_pkg::DSEL_J1;
				cmd.div_start = 1'b1;
				state_d = onf_pkg::S_DJ1_WT;
			end
			onf_pkg::S_DJ1_WT: begin
				cmd.div_sel = onf_pkg::DSEL_J1;
				if (status.div_idle) begin
					cmd.cap_div = 1'b1;
					state_d = onf_pkg::S_RD0;
				end
			end
			// one corner read per cycle, each captured into its corner register in the next state
			onf_pkg::S_RD0: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_corner = 2'd0;
				state_d = onf_pkg::S_RD1;
			end
			onf_pkg::S_RD1: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_corner  = 2'd1;
				cmd.cap_en     = 1'b1;
				cmd.cap_corner = 2'd0;
				state_d = onf_pkg::S_RD2;
			end
			onf_pkg::S_RD2: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_corner  = 2'd2;
				cmd.cap_en     = 1'b1;
				cmd.cap_corner = 2'd1;
				state_d = onf_pkg::S_RD3;
			end
			onf_pkg::S_RD3: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_corner  = 2'd3;
				cmd.cap_en     = 1'b1;
				cmd.cap_corner = 2'd2;
				state_d = onf_pkg::S_RD4;
			end
			onf_pkg::S_RD4: begin
				cmd.cap_en     = 1'b1;
				cmd.cap_corner = 2'd3;
				state_d = onf_pkg::S_TOP;
			end
			onf_pkg::S_TOP: begin
				cmd.blend_top = 1'b1;
				state_d = onf_pkg::S_BOT;
			end
			onf_pkg::S_BOT: begin
				cmd.blend_bot = 1'b1;
				state_d = onf_pkg::S_V1;
			end
			onf_pkg::S_V1: begin
				cmd.blend_v1 = 1'b1;
				state_d = onf_pkg::S_V2;
			end
			onf_pkg::S_V2: begin
				cmd.blend_v2 = 1'b1;
				state_d = status.last_oct ? onf_pkg::S_DACC_GO : onf_pkg::S_SETUP;
			end
			onf_pkg::S_DACC_GO: begin
				cmd.div_sel   = onf_pkg::DSEL_ACC;
				cmd.div_start = 1'b1;
				state_d = onf_pkg::S_DACC_WT;
			end
			onf_pkg::S_DACC_WT: begin
				cmd.div_sel = onf_pkg::DSEL_ACC;
				if (status.div_idle) begin
					cmd.cap_div = 1'b1;
					state_d = onf_pkg::S_OUT;
				end
			end
			onf_pkg::S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = onf_pkg::S_IDLE;
				end
			end
			default: state_d = onf_pkg::S_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> status.div_idle)
		else $error("divider restarted while busy");
`endif

endmodule

[rtl/core/octave_value_noise_field.sv]
// Top level of the octave value-noise field: controller plus datapath.
//
// Input stream (s_*): one transaction per request. s_tuser selects the kind:
// a load writes sample into the base field at pixel_index (no result), a
// read computes the normalized octave sum at pixel_index and returns one
// result on the output stream (m_*) with the index echoed.
// A load is written into the base field as it is accepted. A read is paced
// by the shared one-bit-per-cycle divider (index split, corner wrap, final
// normalize) and by the single read port of the base field.
// Requests are taken one at a time; s_tready is high only between reads.
// The result sits in an output register, so the next request is taken
// while the receiver stalls; a finished read waits only if that register
// is still full.
// Configuration: cfg_we writes cfg_data into the register cfg_idx selects
// (0 width, 1 height, 2 octave count); write only while no read is running.
// Reset restores 64, 64 and 4 and empties the output register; the base
// field is not cleared and must be loaded before it is read.
module octave_value_noise_field (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [onf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [onf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [onf_pkg::IN_DATA_W-1:0]  s_tdata,   // pixel_index[11:0], sample[27:12]
	input  logic [0:0]                     s_tuser,   // req_type[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [onf_pkg::OUT_DATA_W-1:0] m_tdata    // noise_value[15:0], pixel_echo[27:16]
);

	onf_pkg::cmd_t    cmd;
	onf_pkg::status_t status;

	// sequencing: one request at a time, octaves from coarse to fine
	onf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser[0]),
		.status   (status),
		.cmd      (cmd)
	);

	// storage, arithmetic and the output register
	onf_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

[tb/sv/octave_value_noise_field_tb.sv]
// Testbench for octave_value_noise_field: directed table, then random traffic against a predictor.
`timescale 1ns / 1ps

module octave_value_noise_field_tb;
	import onf_pkg::*;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int SAMPLE_FULL = 16'hFFFF;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 400;
	// Side of the square area kept loaded; every read stays inside it.
	localparam int FIELD_SIDE = 16;
	localparam int FIELD_AREA = FIELD_SIDE * FIELD_SIDE;

	typedef struct {
		req_type_t   kind;
		logic [11:0] index;
		logic [15:0] sample;
		bit          pinned;     // expected value typed into the table
		logic [15:0] noise;
	} table_row_t;

	typedef struct {
		logic [15:0] noise;
		logic [11:0] echo;
	} pixel_result_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [IN_DATA_W-1:0] s_tdata;   // pixel_index[11:0], sample[27:12]
	logic [0:0] s_tuser;             // req_type[0]
	logic [OUT_DATA_W-1:0] m_tdata;  // noise_value[15:0], pixel_echo[27:16]

	// Predictor's own copy of the block state.
	logic [15:0] noise_base [STORE_DEPTH];
	logic [6:0] pred_width, pred_height;
	logic [3:0] pred_octaves;

	pixel_result_t pending_pixels[$];
	bit pin_next;
	logic [15:0] pin_value;
	bit stimulus_done;
	int errors = 0;
	int cycles = 0;

	octave_value_noise_field u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Weighted sum of bilinear octaves at one pixel, normalized and saturated.
	function automatic logic [15:0] octave_noise(int unsigned index);
		int unsigned w, h, n, x, y, sh, i0, j0, i1, j1;
		longint unsigned hb, vb, top, bot, acc, quot;
		w = clamp_to(pred_width, MAX_WIDTH);
		h = clamp_to(pred_height, MAX_HEIGHT);
		n = clamp_to(pred_octaves, MAX_OCTAVES);
		x = index % w;
		y = (index / w) % h;
		acc = 0;
		for (int k = 0; k < n; k++) begin
			sh = n - k;
			i0 = (x >> sh) << sh;
			j0 = (y >> sh) << sh;
			i1 = (i0 + (1 << sh)) % w;
			j1 = (j0 + (1 << sh)) % h;
			hb = ((x - i0) << 8) >> sh;
			vb = ((y - j0) << 8) >> sh;
			top = longint'(noise_base[j0 * w + i0]) * (256 - hb)
				+ longint'(noise_base[j0 * w + i1]) * hb;
			bot = longint'(noise_base[j1 * w + i0]) * (256 - hb)
				+ longint'(noise_base[j1 * w + i1]) * hb;
			acc += (top * (256 - vb) + bot * vb) << (n - 1 - k);
		end
		quot = acc / (((64'd1 << n) - 1) << 16);
		if (quot > SAMPLE_FULL) quot = SAMPLE_FULL;
		return quot[15:0];
	endfunction

	// Input side: update the predictor on each accepted transaction.
	// Output side: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		pixel_result_t want;
		cycles <= cycles + 1;
		if (s_tvalid && s_tready) begin
			if (req_type_t'(s_tuser[0]) == REQ_LOAD) begin
				noise_base[s_tdata[11:0]] = s_tdata[27:12];
			end else begin
				want.noise = pin_next ? pin_value : octave_noise(s_tdata[11:0]);
				want.echo = s_tdata[11:0];
				pending_pixels.push_back(want);
			end
		end
		if (m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result: pixel_echo %0d noise_value %0h",
					m_tdata[27:16], m_tdata[15:0]);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[15:0] !== want.noise) begin
					$error("noise_value: expected %0h, actual %0h", want.noise, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[27:16] !== want.echo) begin
					$error("pixel_echo: expected %0d, actual %0d", want.echo, m_tdata[27:16]);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: stall a random number of cycles before each result, with calm stretches.
	initial begin
		int stall;
		bit calm;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 40) == 0) calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	bit sender_calm;

	// Drive one request; enter and leave on a falling edge.
	task automatic push_request(req_type_t kind, logic [11:0] index, logic [15:0] sample);
		int gap;
		if ($urandom_range(0, 40) == 0) sender_calm = !sender_calm;
		gap = sender_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0, sample, index};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH:   pred_width = value;
			REG_HEIGHT:  pred_height = value;
			REG_OCTAVES: pred_octaves = value[3:0];
			default: ;
		endcase
	endtask

	// Hold until every expected result is in and the block has gone quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_traffic(int count);
		logic [11:0] index;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 9))
				0: index = 12'd0;
				1: index = 12'hFFF;
				default: index = 12'($urandom_range(0, 4095));
			endcase
			if ($urandom_range(0, 9) < 6) push_request(REQ_READ, index, 16'($urandom));
			else push_request(REQ_LOAD, index, 16'($urandom));
		end
	endtask

	// Starts on the constant full-scale field, so the first reads are pinned to full scale; later loads break it.
	table_row_t directed[] = '{
		'{REQ_READ, 12'd0,    16'h0,    1'b1, 16'hFFFF},
		'{REQ_READ, 12'd4095, 16'h1234, 1'b1, 16'hFFFF},
		'{REQ_READ, 12'd63,   16'h0,    1'b1, 16'hFFFF},
		'{REQ_READ, 12'd4032, 16'h0,    1'b1, 16'hFFFF},
		'{REQ_LOAD, 12'd0,    16'h0000, 1'b0, 16'h0},
		'{REQ_READ, 12'd0,    16'h0,    1'b0, 16'h0},
		'{REQ_READ, 12'd1,    16'h0,    1'b0, 16'h0},
		'{REQ_LOAD, 12'd4095, 16'h0000, 1'b0, 16'h0},
		'{REQ_READ, 12'd4095, 16'h0,    1'b0, 16'h0},
		'{REQ_READ, 12'd4094, 16'h0,    1'b0, 16'h0},
		'{REQ_LOAD, 12'd100,  16'h8000, 1'b0, 16'h0},
		'{REQ_LOAD, 12'd2730, 16'h5555, 1'b0, 16'h0},
		'{REQ_LOAD, 12'd1365, 16'hAAAA, 1'b0, 16'h0},
		'{REQ_READ, 12'd100,  16'h0,    1'b0, 16'h0},
		'{REQ_READ, 12'd2730, 16'h0,    1'b0, 16'h0},
		'{REQ_READ, 12'd1365, 16'hFFFF, 1'b0, 16'h0},
		'{REQ_READ, 12'd37,   16'h0,    1'b0, 16'h0}
	};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_LOAD;
		pin_next = 1'b0;
		pin_value = '0;
		pred_width = 7'd64;
		pred_height = 7'd64;
		pred_octaves = 4'd4;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Work on a small square so the whole area in use can be loaded.
		write_reg(REG_WIDTH, 7'(FIELD_SIDE));
		write_reg(REG_HEIGHT, 7'(FIELD_SIDE));

		// Fill the area in use so no read ever touches an unwritten entry.
		for (int a = 0; a < FIELD_AREA; a++) push_request(REQ_LOAD, 12'(a), 16'(SAMPLE_FULL));

		foreach (directed[r]) begin
			pin_next = directed[r].pinned;
			pin_value = directed[r].noise;
			push_request(directed[r].kind, directed[r].index, directed[r].sample);
		end
		pin_next = 1'b0;
		settle();

		// Random content over the area, then traffic at four octaves.
		for (int a = 0; a < FIELD_AREA; a++) push_request(REQ_LOAD, 12'(a), 16'($urandom));
		random_traffic(150);
		settle();

		// Smallest field, one octave.
		write_reg(REG_WIDTH, 7'd1);
		write_reg(REG_HEIGHT, 7'd1);
		write_reg(REG_OCTAVES, 7'd1);
		random_traffic(80);
		settle();

		// Zero values act as one; unknown index must be ignored.
		write_reg(REG_WIDTH, 7'd0);
		write_reg(REG_HEIGHT, 7'd0);
		write_reg(REG_OCTAVES, 7'd0);
		write_reg(REG_NONE, 7'h7F);
		random_traffic(60);
		settle();

		// Over-range values clamp to the maximum: full width in one row.
		write_reg(REG_WIDTH, 7'd127);
		write_reg(REG_HEIGHT, 7'd1);
		write_reg(REG_OCTAVES, 7'd15);
		random_traffic(100);
		settle();

		// Full height in one column.
		write_reg(REG_WIDTH, 7'd1);
		write_reg(REG_HEIGHT, 7'd127);
		random_traffic(80);
		settle();

		// Loaded square at eight octaves, then odd sizes where wrap matters.
		write_reg(REG_WIDTH, 7'(FIELD_SIDE));
		write_reg(REG_HEIGHT, 7'(FIELD_SIDE));
		write_reg(REG_OCTAVES, 7'd8);
		random_traffic(100);
		settle();

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_WIDTH, 7'($urandom_range(1, FIELD_SIDE)));
			write_reg(REG_HEIGHT, 7'($urandom_range(1, FIELD_SIDE)));
			write_reg(REG_OCTAVES, 7'($urandom_range(1, 8)));
			random_traffic(40);
			settle();
		end

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
